>>> hw/rtl/speed_pi_conditional_antiwindup_assert.svh
// assertion macros for the speed pi controller
// expects clk and rst to be visible where the macros are used
`ifndef SPEED_PI_CONDITIONAL_ANTIWINDUP_ASSERT_SVH
`define SPEED_PI_CONDITIONAL_ANTIWINDUP_ASSERT_SVH

// same-cycle implication
`define SPDPI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("speed pi assertion failed");

// next-cycle implication
`define SPDPI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("speed pi assertion failed");

`endif

>>> hw/rtl/spdpi_pkg.sv
// shared types and constants for the speed pi controller
// no dependencies
`default_nettype none

package spdpi_pkg;

  // field widths
  localparam int SpeedW   = 20;
  localparam int ErrW     = SpeedW + 1;
  localparam int KpW      = 24;
  localparam int KiW      = 24;
  localparam int OutW     = 16;
  localparam int FracW    = 16;
  localparam int ProdW    = KpW + ErrW;
  localparam int PShift   = 4;
  localparam int IncShift = 12;
  localparam int PW       = ProdW - PShift;
  localparam int IncW     = ProdW - IncShift;
  localparam int IntegW   = 48;
  localparam int SumW     = IntegW + 2;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 24;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SPEED_MODE = 8'd0,
    REG_KP         = 8'd1,
    REG_KI_DT      = 8'd2,
    REG_OUT_MAX    = 8'd3
  } cfg_reg_t;

  // register reset values
  localparam logic          RstSpeedMode = 1'b1;
  localparam logic [KpW-1:0]  RstKp      = 24'd13107;
  localparam logic [KiW-1:0]  RstKiDt    = 24'd0;
  localparam logic [OutW-1:0] RstOutMax  = 16'd4095;

  // accepted input item
  typedef struct packed {
    logic signed [SpeedW-1:0] speed_ref;
    logic signed [SpeedW-1:0] speed_meas;
    logic                     run_enable;
  } in_t;

  // products and error flags handed to the integrator stage
  typedef struct packed {
    logic signed [PW-1:0]   p;
    logic signed [IncW-1:0] inc;
    logic                   err_neg;
    logic                   err_pos;
    logic                   run;
  } prod_t;

  // stage load strobes
  typedef struct packed {
    logic load_prod;
    logic load_res;
  } pipe_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/spdpi_mul.sv
// error and gain products stage of the speed pi controller
// depends on spdpi_pkg
`default_nettype none

module spdpi_mul (
  input  wire logic                             clk,
  input  wire spdpi_pkg::pipe_ctl_t             ctl,
  input  wire spdpi_pkg::in_t                   in_q,
  input  wire logic [spdpi_pkg::KpW-1:0]        kp,
  input  wire logic [spdpi_pkg::KiW-1:0]        ki_dt,
  output spdpi_pkg::prod_t                      prod
);

  logic signed [spdpi_pkg::ErrW-1:0]  err;
  logic signed [spdpi_pkg::ProdW-1:0] kp_prod;
  logic signed [spdpi_pkg::ProdW-1:0] ki_prod;
  spdpi_pkg::prod_t                   prod_next;

  // speed error, exact in one extra bit
  assign err = {in_q.speed_ref[spdpi_pkg::SpeedW-1], in_q.speed_ref}
             - {in_q.speed_meas[spdpi_pkg::SpeedW-1], in_q.speed_meas};

  // gain products, signed
  assign kp_prod = $signed({1'b0, kp}) * err;
  assign ki_prod = $signed({1'b0, ki_dt}) * err;

  // arithmetic shifts by part-select give floor rounding
  always_comb begin
    prod_next.p       = kp_prod[spdpi_pkg::ProdW-1:spdpi_pkg::PShift];
    prod_next.inc     = ki_prod[spdpi_pkg::ProdW-1:spdpi_pkg::IncShift];
    prod_next.err_neg = err[spdpi_pkg::ErrW-1];
    prod_next.err_pos = !err[spdpi_pkg::ErrW-1] && (|err);
    prod_next.run     = in_q.run_enable;
  end

  // product register
  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod <= prod_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/spdpi_integ.sv
// integrator with conditional anti-windup, output clamp and result register
// depends on spdpi_pkg
`default_nettype none

module spdpi_integ (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire spdpi_pkg::pipe_ctl_t          ctl,
  input  wire spdpi_pkg::prod_t              prod,
  input  wire logic                          speed_mode,
  input  wire logic [spdpi_pkg::OutW-1:0]    out_max,
  output logic [spdpi_pkg::OutW-1:0]         drive,
  output logic                               integral_frozen
);

  localparam int IW = spdpi_pkg::IntegW;
  localparam int SW = spdpi_pkg::SumW;

  logic signed [IW-1:0] integ;
  logic signed [IW:0]   cand_wide;
  logic signed [IW-1:0] cand;
  logic signed [SW-1:0] hi;
  logic signed [SW-1:0] unsat;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] sum_clamped;
  logic signed [IW-1:0] integ_next;
  logic                 above;
  logic                 below;
  logic                 accept;
  logic                 active;

  assign active = prod.run && speed_mode;

  // candidate integral, saturated to the accumulator range
  assign cand_wide = {integ[IW-1], integ}
                   + {{(IW + 1 - spdpi_pkg::IncW){prod.inc[spdpi_pkg::IncW-1]}}, prod.inc};

  always_comb begin
    if (cand_wide[IW] != cand_wide[IW-1]) begin
      cand = cand_wide[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    end else begin
      cand = cand_wide[IW-1:0];
    end
  end

  // upper bound in the integral's fraction format
  assign hi = {{(SW - spdpi_pkg::OutW - spdpi_pkg::FracW){1'b0}}, out_max,
               {spdpi_pkg::FracW{1'b0}}};

  // accept when in range or when the error pulls back toward it
  assign unsat = {{(SW - spdpi_pkg::PW){prod.p[spdpi_pkg::PW-1]}}, prod.p}
               + {{(SW - IW){cand[IW-1]}}, cand};
  assign below  = unsat[SW-1];
  assign above  = unsat > hi;
  assign accept = (!above && !below) || (above && prod.err_neg) || (below && prod.err_pos);
  assign integ_next = accept ? cand : integ;

  // drive sum and clamp
  assign sum = {{(SW - spdpi_pkg::PW){prod.p[spdpi_pkg::PW-1]}}, prod.p}
             + {{(SW - IW){integ_next[IW-1]}}, integ_next};

  always_comb begin
    if (sum[SW-1]) begin
      sum_clamped = '0;
    end else if (sum > hi) begin
      sum_clamped = hi;
    end else begin
      sum_clamped = sum;
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
    end else if (ctl.load_res) begin
      integ <= active ? integ_next : '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.load_res) begin
      if (active) begin
        drive           <= sum_clamped[spdpi_pkg::FracW + spdpi_pkg::OutW - 1:spdpi_pkg::FracW];
        integral_frozen <= !accept;
      end else begin
        drive           <= '0;
        integral_frozen <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/speed_pi_conditional_antiwindup.sv
// top level of the speed pi controller: handshake, configuration registers, stages
// depends on spdpi_pkg, spdpi_mul, spdpi_integ and the assertion macro header
`default_nettype none

`include "speed_pi_conditional_antiwindup_assert.svh"

// Speed PI controller with conditional-integration anti-windup. Each item
// (speed_ref, speed_meas, run_enable) gives one result (drive, integral_frozen)
// on the result ports. The item passes an input register, a register after the
// two gain multipliers, and the result register that is loaded together with
// the integral accumulator. One item is accepted every clock while the output
// is not stalled; the rate is set by the accumulator update, which is done
// combinationally in the last stage. Configuration writes on the cfg channel
// are always ready and take effect at once; write them only while no item is
// in flight. Register indexes: 0 speed_mode, 1 kp, 2 ki_dt, 3 out_max; other
// indexes are ignored.
module speed_pi_conditional_antiwindup (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // input channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [spdpi_pkg::SpeedW-1:0]  speed_ref,
  input  wire logic signed [spdpi_pkg::SpeedW-1:0]  speed_meas,
  input  wire logic                                 run_enable,
  // output channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [spdpi_pkg::OutW-1:0]                drive,
  output logic                                      integral_frozen,
  // configuration channel
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [spdpi_pkg::CfgIdxW-1:0]        cfg_index,
  input  wire logic [spdpi_pkg::CfgDataW-1:0]       cfg_data
);

  logic                         speed_mode;
  logic [spdpi_pkg::KpW-1:0]    kp;
  logic [spdpi_pkg::KiW-1:0]    ki_dt;
  logic [spdpi_pkg::OutW-1:0]   out_max;

  logic                         iv;
  logic                         pv;
  logic                         rv;
  logic                         in_take;
  logic                         res_off;
  spdpi_pkg::in_t               in_q;
  spdpi_pkg::prod_t             prod;
  spdpi_pkg::pipe_ctl_t         ctl;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_mode <= spdpi_pkg::RstSpeedMode;
      kp         <= spdpi_pkg::RstKp;
      ki_dt      <= spdpi_pkg::RstKiDt;
      out_max    <= spdpi_pkg::RstOutMax;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spdpi_pkg::REG_SPEED_MODE: speed_mode <= cfg_data[0];
        spdpi_pkg::REG_KP:         kp         <= cfg_data[spdpi_pkg::KpW-1:0];
        spdpi_pkg::REG_KI_DT:      ki_dt      <= cfg_data[spdpi_pkg::KiW-1:0];
        spdpi_pkg::REG_OUT_MAX:    out_max    <= cfg_data[spdpi_pkg::OutW-1:0];
        default: ;
      endcase
    end
  end

  // stage advance: a stage moves when the next one is empty or moving
  always_comb begin
    ctl.load_res  = pv && (!rv || !out_stall);
    ctl.load_prod = iv && (!pv || ctl.load_res);
  end

  assign in_stall  = iv && !ctl.load_prod;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = rv;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
      pv <= 1'b0;
      rv <= 1'b0;
    end else begin
      if (in_take) begin
        iv <= 1'b1;
      end else if (ctl.load_prod) begin
        iv <= 1'b0;
      end
      if (ctl.load_prod) begin
        pv <= 1'b1;
      end else if (ctl.load_res) begin
        pv <= 1'b0;
      end
      if (ctl.load_res) begin
        rv <= 1'b1;
      end else if (!out_stall) begin
        rv <= 1'b0;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q.speed_ref  <= speed_ref;
      in_q.speed_meas <= speed_meas;
      in_q.run_enable <= run_enable;
    end
  end

  spdpi_mul u_mul (
    .clk   (clk),
    .ctl   (ctl),
    .in_q  (in_q),
    .kp    (kp),
    .ki_dt (ki_dt),
    .prod  (prod)
  );

  spdpi_integ u_integ (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .prod            (prod),
    .speed_mode      (speed_mode),
    .out_max         (out_max),
    .drive           (drive),
    .integral_frozen (integral_frozen)
  );

  // checks
  assign res_off = ctl.load_res && !(prod.run && speed_mode);

  `SPDPI_ASSERT_IMP(a_drive_in_range, out_valid, drive <= out_max)
  `SPDPI_ASSERT_NEXT(a_off_clears, res_off, drive == '0 && !integral_frozen)
  `SPDPI_ASSERT_IMP(a_stall_only_full, in_stall, iv && pv && rv)

endmodule

`default_nettype wire

>>> tb/sv/spdpi_tb_pkg.sv
`timescale 1ns / 1ps
// drive prediction and result checking for the speed pi controller testbench
// depends on spdpi_pkg for field widths, register indexes and reset values
package spdpi_tb_pkg;
  import spdpi_pkg::*;

  // signed 48-bit integrator limits
  localparam longint Int48Max = (64'sd1 <<< 47) - 64'sd1;
  localparam longint Int48Min = -(64'sd1 <<< 47);

  // one expected result item
  typedef struct packed {
    logic [OutW-1:0] drive;
    logic            frozen;
  } drive_result_t;

  class drive_scoreboard;
    bit              speed_mode;
    bit [KpW-1:0]    kp;
    bit [KiW-1:0]    ki_dt;
    bit [OutW-1:0]   out_max;
    longint          integ_acc;
    drive_result_t   expected_q[$];
    int              mismatch_count;
    int              tick_count;
    int              result_count;

    function new();
      speed_mode     = RstSpeedMode;
      kp             = RstKp;
      ki_dt          = RstKiDt;
      out_max        = RstOutMax;
      integ_acc      = 0;
      mismatch_count = 0;
      tick_count     = 0;
      result_count   = 0;
    endfunction

    // register write, unknown indexes leave everything alone
    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_SPEED_MODE: speed_mode = data[0];
        REG_KP:         kp = data[KpW-1:0];
        REG_KI_DT:      ki_dt = data[KiW-1:0];
        REG_OUT_MAX:    out_max = data[OutW-1:0];
        default: ;
      endcase
    endfunction

    // one control tick: pi terms, conditional integration, output clamp
    function drive_result_t predict_tick(logic signed [SpeedW-1:0] sref,
                                         logic signed [SpeedW-1:0] meas, logic run);
      longint        err;
      longint        p;
      longint        inc;
      longint        cand;
      longint        hi;
      longint        unsat;
      longint        sum;
      bit            take;
      drive_result_t r;
      if (!run || !speed_mode) begin
        integ_acc = 0;
        r.drive = '0;
        r.frozen = 1'b0;
        return r;
      end
      err = longint'(sref) - longint'(meas);
      p = (longint'(kp) * err) >>> PShift;
      inc = (longint'(ki_dt) * err) >>> IncShift;
      // candidate integral saturates at the 48-bit limits
      cand = integ_acc + inc;
      if (cand > Int48Max) begin
        cand = Int48Max;
      end else if (cand < Int48Min) begin
        cand = Int48Min;
      end
      hi = longint'(out_max) <<< FracW;
      unsat = p + cand;
      // accept inside the range, or when the error pulls back toward it
      take = (unsat >= 0 && unsat <= hi) || (unsat > hi && err < 0) ||
             (unsat < 0 && err > 0);
      if (take) begin
        integ_acc = cand;
      end
      sum = p + integ_acc;
      if (sum < 0) begin
        sum = 0;
      end else if (sum > hi) begin
        sum = hi;
      end
      r.drive = sum[31:16];
      r.frozen = !take;
      return r;
    endfunction

    function void note_tick(logic signed [SpeedW-1:0] sref,
                            logic signed [SpeedW-1:0] meas, logic run);
      expected_q.push_back(predict_tick(sref, meas, run));
      tick_count++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
    endtask

    // compare one accepted result item with the oldest expectation
    task check_result(logic [OutW-1:0] drive, logic frozen);
      drive_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("drive %0d arrived with no tick outstanding", drive));
      end else begin
        want = expected_q.pop_front();
        if (drive !== want.drive) begin
          report_mismatch($sformatf("result %0d drive %0d, expected %0d",
                                    result_count, drive, want.drive));
        end
        if (frozen !== want.frozen) begin
          report_mismatch($sformatf("result %0d integral_frozen %b, expected %b",
                                    result_count, frozen, want.frozen));
        end
        result_count++;
      end
    endtask
  endclass

endpackage

>>> tb/sv/speed_pi_conditional_antiwindup_tb.sv
`timescale 1ns / 1ps
// top-level testbench for the speed pi controller: clock, reset, drivers, phases
// depends on spdpi_pkg, spdpi_tb_pkg and the speed_pi_conditional_antiwindup rtl
module speed_pi_conditional_antiwindup_tb;
  import spdpi_pkg::*;
  import spdpi_tb_pkg::*;

  localparam int StallLimit = 3000;
  localparam int HoldCycles = 400;
  localparam int PhaseCount = 8;
  localparam int PhaseTicks = 50;
  localparam logic [CfgIdxW-1:0] RegOutOfRange = 8'hFF;
  localparam logic signed [SpeedW-1:0] SpeedMax = 20'sh7FFFF;
  localparam logic signed [SpeedW-1:0] SpeedMin = 20'sh80000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SpeedW-1:0] speed_ref = '0;
  logic signed [SpeedW-1:0] speed_meas = '0;
  logic run_enable = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [OutW-1:0] drive;
  logic integral_frozen;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  drive_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;

  speed_pi_conditional_antiwindup dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .speed_ref(speed_ref),
    .speed_meas(speed_meas),
    .run_enable(run_enable),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .drive(drive),
    .integral_frozen(integral_frozen),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // result side: check accepted items, then pick the next stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        sb.check_result(drive, integral_frozen);
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
                 (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one tick item after an optional random gap, return once accepted
  task send_tick(logic signed [SpeedW-1:0] sref, logic signed [SpeedW-1:0] meas,
                 logic run);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    speed_ref <= sref;
    speed_meas <= meas;
    run_enable <= run;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_tick(sref, meas, run);
  endtask

  // register write, valid is left high for back-to-back writes
  task write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_reg(idx, data);
    reg_writes++;
  endtask

  // stop offering and wait until every expected result has come back
  task drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    int ph;
    int n;
    int pick;
    int offset;
    int idle_mode;
    logic signed [SpeedW-1:0] setpoint;
    logic signed [SpeedW-1:0] sref;
    logic signed [SpeedW-1:0] meas;
    logic run;
    logic [KpW-1:0] kp_v;
    logic [KiW-1:0] ki_v;
    logic [OutW-1:0] om_v;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: moderate gains, then extremes of the error
    write_reg(REG_SPEED_MODE, 24'd1);
    write_reg(REG_KP, 24'd13107);
    write_reg(REG_KI_DT, 24'h040000);
    write_reg(REG_OUT_MAX, 24'd4095);
    write_reg(RegOutOfRange, 24'hFFFFFF);
    cfg_valid <= 1'b0;
    send_tick(20'sd0, 20'sd0, 1'b1);
    send_tick(SpeedMax, SpeedMin, 1'b1);
    send_tick(SpeedMin, SpeedMax, 1'b1);
    send_tick(SpeedMax, SpeedMin, 1'b0);
    for (n = 0; n < 6; n++) begin
      send_tick(20'sd1600, 20'sd0, 1'b1);
    end
    send_tick(20'sd1600, 20'sd1600, 1'b1);
    for (n = 0; n < 3; n++) begin
      send_tick(20'sd0, 20'sd800, 1'b1);
    end
    drain_results();

    // pure integral with the widest clamp builds a large accumulator
    write_reg(REG_KP, 24'd0);
    write_reg(REG_KI_DT, 24'hFFFFFF);
    write_reg(REG_OUT_MAX, 24'h00FFFF);
    cfg_valid <= 1'b0;
    for (n = 0; n < 5; n++) begin
      send_tick(20'sd16000, 20'sd0, 1'b1);
    end
    drain_results();

    // clamp collapsed to zero: zero error holds, negative error pulls back
    write_reg(REG_OUT_MAX, 24'd0);
    cfg_valid <= 1'b0;
    send_tick(20'sd0, 20'sd0, 1'b1);
    send_tick(20'sd0, 20'sd16, 1'b1);
    drain_results();

    // speed mode off clears the controller even with run enabled
    write_reg(REG_SPEED_MODE, 24'd0);
    cfg_valid <= 1'b0;
    send_tick(20'sd1600, 20'sd0, 1'b1);
    drain_results();

    // random phases, each setting its gains and idling pattern
    setpoint = '0;
    for (ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: begin
          kp_v = 24'd13107;
          ki_v = 24'h010000;
          om_v = 16'd4095;
        end
        1: begin
          kp_v = '1;
          ki_v = '1;
          om_v = '1;
        end
        2: begin
          kp_v = '0;
          ki_v = '0;
          om_v = '0;
        end
        default: begin
          pick = $urandom_range(2);
          kp_v = (pick == 0) ? 24'($urandom) :
                 (pick == 1) ? 24'($urandom_range(65535)) : 24'($urandom_range(1023));
          pick = $urandom_range(2);
          ki_v = (pick == 0) ? 24'($urandom) :
                 (pick == 1) ? 24'($urandom_range(1 << 20)) : 24'($urandom_range(4096));
          om_v = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(8191));
        end
      endcase
      write_reg(REG_SPEED_MODE, (ph == 6) ? 24'd0 : 24'd1);
      write_reg(REG_KP, kp_v);
      write_reg(REG_KI_DT, ki_v);
      write_reg(REG_OUT_MAX, {8'd0, om_v});
      cfg_valid <= 1'b0;

      idle_mode = (ph == 5) ? 0 : ph % 4;
      case (idle_mode)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct = 88;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 88;
        end
        default: begin
          tx_idle_pct = 13;
          rx_stall_pct <= 13;
        end
      endcase
      // long output hold while the sender keeps offering
      if (ph == 5) begin
        hold_token <= hold_token + 1;
      end

      for (n = 0; n < PhaseTicks; n++) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          // tracking: measured speed near a setpoint that moves now and then
          if ($urandom_range(15) == 0) begin
            setpoint = 20'($urandom);
          end
          offset = $urandom_range(8000) - 4000;
          sref = setpoint;
          meas = 20'(setpoint - offset);
          run = ($urandom_range(31) != 0);
        end else if (pick < 95) begin
          sref = 20'($urandom);
          meas = 20'($urandom);
          run = 1'($urandom);
        end else begin
          sref = 20'($urandom);
          meas = 20'($urandom);
          run = 1'b0;
        end
        send_tick(sref, meas, run);
      end
      drain_results();
    end

    // let the pipeline settle to catch any stray result
    rx_stall_pct <= 0;
    repeat (8) @(posedge clk);

    $display("ran %0d control ticks and %0d results through %0d register writes",
             sb.tick_count, sb.result_count, reg_writes);
    $display("phases: full rate, sparse sender, stalled receiver, mixed idle, long hold");
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/spdpi_pkg.sv
hw/rtl/spdpi_mul.sv
hw/rtl/spdpi_integ.sv
hw/rtl/speed_pi_conditional_antiwindup.sv
tb/sv/spdpi_tb_pkg.sv
tb/sv/speed_pi_conditional_antiwindup_tb.sv
